[rtl/core/fdl_pkg.sv]
// Shared types, codes and fixed constants of the fractional delay line.
package fdl_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHOLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRACTION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDELOBE = 3'd3;

    // Request kinds and interpolation modes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_COEF    = 1'b1;
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_SINC   = 1'b1;

    // Fixed field widths and Q15 arithmetic
    localparam int COEF_W       = 16;
    localparam int COEF_INDEX_W = 5;
    localparam int WHOLE_W      = 8;
    localparam int FRACTION_W   = 16;
    localparam int SIDELOBE_W   = 5;
    localparam int WEIGHT_W     = 17;
    localparam logic [FRACTION_W-1:0] FRAC_ONE = 16'h8000;
    localparam int ROUND_HALF   = 16384;
    localparam int FRAC_SHIFT   = 15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fdl_state_t;

    typedef struct packed {
        logic acc_clear;
        logic issue;
        logic linear;
        logic right_tap;
        logic use_input;
    } fdl_mac_ctl_t;

endpackage

[rtl/core/fdl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/fdl_mac.sv]
// Multiply-accumulate datapath with rounding and saturation of the result.
module fdl_mac #(
    parameter int SAMPLE_BITS   = 16,
    parameter int MAX_SIDELOBES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fdl_pkg::fdl_mac_ctl_t          ctl,
    input  logic signed [fdl_pkg::COEF_W-1:0] tap_rdata,
    input  logic signed [SAMPLE_BITS-1:0]  smp_rdata,
    input  logic signed [SAMPLE_BITS-1:0]  sample_x,
    input  logic [fdl_pkg::FRACTION_W-1:0] frac,
    output logic                           busy,
    output logic signed [SAMPLE_BITS-1:0]  result
);

    import fdl_pkg::*;

    localparam int TAPS   = 2 * MAX_SIDELOBES;
    localparam int PROD_W = WEIGHT_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
    localparam int QW     = ACC_W - FRAC_SHIFT;

    logic                       v1_reg;
    logic                       lin1_reg;
    logic                       right1_reg;
    logic                       usex1_reg;
    logic                       v2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic signed [WEIGHT_W-1:0]    weight;
    logic signed [SAMPLE_BITS-1:0] operand;
    logic signed [ACC_W-1:0]       rounded;
    logic signed [QW-1:0]          quot;

    // The control of an issued tap is registered so that it lines up with the RAM data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
        end
        lin1_reg   <= ctl.linear;
        right1_reg <= ctl.right_tap;
        usex1_reg  <= ctl.use_input;
    end

    always_comb begin
        if (lin1_reg) begin
            if (right1_reg) begin
                weight = signed'({1'b0, FRAC_ONE} - {1'b0, frac});
            end else begin
                weight = signed'({1'b0, frac});
            end
        end else begin
            weight = WEIGHT_W'(tap_rdata);
        end
        operand = usex1_reg ? sample_x : smp_rdata;
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= weight * operand;
        end
        if (ctl.acc_clear) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = v1_reg | v2_reg;

    // Round half up, then clamp to the signed sample range.
    always_comb begin
        rounded = acc_reg + ACC_W'(ROUND_HALF);
        quot    = rounded[ACC_W-1:FRAC_SHIFT];
        if ((quot[QW-1:SAMPLE_BITS-1] == '0) || (quot[QW-1:SAMPLE_BITS-1] == '1)) begin
            result = quot[SAMPLE_BITS-1:0];
        end else if (quot[QW-1]) begin
            result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

[rtl/core/fdl_ctrl.sv]
// Sequencer: configuration, buffer pointers, clearing pass and tap issue.
module fdl_ctrl #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int MAX_SIDELOBES = 16,
    parameter int SAMPLE_BITS   = 16,
    localparam int AW  = $clog2(BUFFER_DEPTH),
    localparam int TAW = $clog2(2 * MAX_SIDELOBES)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_cmd,
    input  logic signed [SAMPLE_BITS-1:0]     in_sample,
    input  logic [fdl_pkg::COEF_INDEX_W-1:0]  in_coef_index,
    input  logic signed [fdl_pkg::COEF_W-1:0] in_coef_value,
    input  logic                              out_free,
    output logic                              result_load,
    output logic                              smp_we,
    output logic [AW-1:0]                     smp_waddr,
    output logic [SAMPLE_BITS-1:0]            smp_wdata,
    output logic [AW-1:0]                     smp_raddr,
    output logic                              tap_we,
    output logic [TAW-1:0]                    tap_waddr,
    output logic [fdl_pkg::COEF_W-1:0]        tap_wdata,
    output logic [TAW-1:0]                    tap_raddr,
    output fdl_pkg::fdl_mac_ctl_t             mac_ctl,
    input  logic                              mac_busy,
    output logic signed [SAMPLE_BITS-1:0]     sample_x,
    output logic [fdl_pkg::FRACTION_W-1:0]    frac
);

    import fdl_pkg::*;

    localparam int TAPS      = 2 * MAX_SIDELOBES;
    localparam int CLR_N     = (BUFFER_DEPTH > TAPS) ? BUFFER_DEPTH : TAPS;
    localparam int CLW       = $clog2(CLR_N);
    localparam int DW        = (AW > WHOLE_W) ? AW : WHOLE_W;
    localparam int NW        = $clog2(MAX_SIDELOBES + 1);
    localparam int NCW       = (NW > SIDELOBE_W) ? NW : SIDELOBE_W;
    localparam int SW        = ((AW + 1 > NW) ? AW + 1 : NW) + 1;
    localparam int SUB_STEPS = (MAX_SIDELOBES + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
    localparam int IW        = (TAW + 1 > COEF_INDEX_W) ? TAW + 1 : COEF_INDEX_W;
    // After reset N is one and C is zero, so one sample is absorbed first.
    localparam logic [NW-1:0] RESET_PRELOAD = NW'(1);

    fdl_state_t state_reg, state_next;

    logic                  mode_reg;
    logic [WHOLE_W-1:0]    whole_reg;
    logic [FRACTION_W-1:0] fraction_reg;
    logic [SIDELOBE_W-1:0] sidelobe_reg;

    logic [CLW-1:0]        clr_cnt_reg;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         ws_reg;
    logic [NW-1:0]         preload_reg;
    logic [AW-1:0]         p_reg;
    logic [TAW-1:0]        k_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;

    logic                  accept;
    logic                  arm_hit;
    logic                  mode_new;
    logic [WHOLE_W-1:0]    whole_new;
    logic [FRACTION_W-1:0] fraction_new;
    logic [SIDELOBE_W-1:0] sidelobe_new;
    logic [AW-1:0]         d_new, d_cur;
    logic [FRACTION_W-1:0] f_new;
    logic [NW-1:0]         n_new, n_cur;
    logic [AW:0]           c_new;
    logic [SW-1:0]         span;
    logic [AW:0]           ws_sum;
    logic [AW-1:0]         arm_ws;
    logic [NW-1:0]         arm_pre;
    logic [AW:0]           li_sum;
    logic [AW-1:0]         li;
    logic [TAW:0]          n2;
    logic                  last;
    logic                  coef_ok;

    function automatic logic [AW-1:0] eff_d(input logic [WHOLE_W-1:0] v);
        logic [DW-1:0] ext;
        ext = DW'(v);
        return (ext > DW'(BUFFER_DEPTH - 1)) ? AW'(BUFFER_DEPTH - 1) : ext[AW-1:0];
    endfunction

    function automatic logic [FRACTION_W-1:0] eff_f(input logic [FRACTION_W-1:0] v);
        return (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

    function automatic logic [NW-1:0] eff_n(input logic [SIDELOBE_W-1:0] v);
        logic [NCW-1:0] ext;
        ext = NCW'(v);
        if (ext == '0) begin
            return NW'(1);
        end else if (ext > NCW'(MAX_SIDELOBES)) begin
            return NW'(MAX_SIDELOBES);
        end
        return ext[NW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] v);
        return (v == AW'(BUFFER_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Values of the registers after this cycle's write, for re-arming the window.
    always_comb begin
        arm_hit = cfg_wr_en && ((cfg_wr_index == REG_MODE) || (cfg_wr_index == REG_WHOLE) ||
                  (cfg_wr_index == REG_FRACTION) || (cfg_wr_index == REG_SIDELOBE));
        mode_new     = mode_reg;
        whole_new    = whole_reg;
        fraction_new = fraction_reg;
        sidelobe_new = sidelobe_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MODE:     mode_new     = cfg_wr_data[0];
                REG_WHOLE:    whole_new    = cfg_wr_data[WHOLE_W-1:0];
                REG_FRACTION: fraction_new = cfg_wr_data[FRACTION_W-1:0];
                REG_SIDELOBE: sidelobe_new = cfg_wr_data[SIDELOBE_W-1:0];
                default:      mode_new     = mode_reg;
            endcase
        end
    end

    always_comb begin
        d_new = eff_d(whole_new);
        f_new = eff_f(fraction_new);
        n_new = eff_n(sidelobe_new);
        c_new = (AW + 1)'(d_new) + (AW + 1)'(f_new != '0);
        span  = SW'(n_new) + SW'(c_new) - SW'(1);
        // The window offset is reduced modulo the depth by a few compare-subtracts.
        for (int i = 0; i < SUB_STEPS; i++) begin
            if (span >= SW'(BUFFER_DEPTH)) begin
                span = span - SW'(BUFFER_DEPTH);
            end
        end
        ws_sum = (AW + 1)'(wp_reg) + (AW + 1)'(BUFFER_DEPTH) - (AW + 1)'(span[AW-1:0]);
        if (ws_sum >= (AW + 1)'(BUFFER_DEPTH)) begin
            ws_sum = ws_sum - (AW + 1)'(BUFFER_DEPTH);
        end
        arm_ws  = ws_sum[AW-1:0];
        arm_pre = (SW'(n_new) > SW'(c_new)) ? NW'(SW'(n_new) - SW'(c_new)) : '0;
    end

    always_comb begin
        d_cur  = eff_d(whole_reg);
        frac   = eff_f(fraction_reg);
        n_cur  = eff_n(sidelobe_reg);
        li_sum = (AW + 1)'(wp_reg) + (AW + 1)'(BUFFER_DEPTH) - (AW + 1)'(d_cur) - (AW + 1)'(1);
        if (li_sum >= (AW + 1)'(BUFFER_DEPTH)) begin
            li_sum = li_sum - (AW + 1)'(BUFFER_DEPTH);
        end
        li      = li_sum[AW-1:0];
        n2      = (mode_reg == MODE_LINEAR) ? (TAW + 1)'(2) : (TAW + 1)'({n_cur, 1'b0});
        last    = ((TAW + 1)'(k_reg) == n2 - (TAW + 1)'(1));
        coef_ok = (IW'(in_coef_index) < IW'(TAPS));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLW'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (in_cmd == CMD_SAMPLE) &&
                    ((mode_reg == MODE_LINEAR) || (preload_reg == '0))) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        smp_we    = 1'b0;
        smp_waddr = wp_reg;
        smp_wdata = in_sample;
        tap_we    = 1'b0;
        tap_waddr = TAW'(in_coef_index);
        tap_wdata = in_coef_value;
        mac_ctl   = '0;
        result_load = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                smp_we    = ({1'b0, clr_cnt_reg} < (CLW + 1)'(BUFFER_DEPTH));
                smp_waddr = clr_cnt_reg[AW-1:0];
                smp_wdata = '0;
                tap_we    = ({1'b0, clr_cnt_reg} < (CLW + 1)'(TAPS));
                tap_waddr = clr_cnt_reg[TAW-1:0];
                tap_wdata = '0;
            end
            ST_IDLE: begin
                if (accept && (in_cmd == CMD_COEF)) begin
                    tap_we = coef_ok;
                end
                if (accept && (in_cmd == CMD_SAMPLE)) begin
                    mac_ctl.acc_clear = 1'b1;
                    // Sinc mode stores the sample before the window is read.
                    smp_we = (mode_reg == MODE_SINC);
                end
            end
            ST_RUN: begin
                mac_ctl.issue     = 1'b1;
                mac_ctl.linear    = (mode_reg == MODE_LINEAR);
                mac_ctl.right_tap = (k_reg != '0);
                mac_ctl.use_input = (mode_reg == MODE_LINEAR) && (k_reg != '0) && (d_cur == '0);
                // Linear mode stores the sample only once both taps have been read.
                if (last && (mode_reg == MODE_LINEAR)) begin
                    smp_we    = 1'b1;
                    smp_wdata = x_reg;
                end
            end
            ST_DONE: begin
                result_load = out_free;
            end
            default: result_load = 1'b0;
        endcase
    end

    assign smp_raddr = p_reg;
    assign tap_raddr = k_reg;
    assign sample_x  = x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            mode_reg     <= MODE_LINEAR;
            whole_reg    <= '0;
            fraction_reg <= '0;
            sidelobe_reg <= SIDELOBE_W'(1);
            wp_reg       <= '0;
            ws_reg       <= '0;
            preload_reg  <= RESET_PRELOAD;
            p_reg        <= '0;
            k_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            mode_reg     <= mode_new;
            whole_reg    <= whole_new;
            fraction_reg <= fraction_new;
            sidelobe_reg <= sidelobe_new;
            if (arm_hit) begin
                ws_reg      <= arm_ws;
                preload_reg <= arm_pre;
            end
            if (accept && (in_cmd == CMD_SAMPLE)) begin
                k_reg <= '0;
                if (mode_reg == MODE_LINEAR) begin
                    p_reg <= li;
                end else begin
                    wp_reg <= inc_ptr(wp_reg);
                    if (preload_reg != '0) begin
                        preload_reg <= preload_reg - 1'b1;
                    end else begin
                        p_reg  <= ws_reg;
                        ws_reg <= inc_ptr(ws_reg);
                    end
                end
            end
            if (state_reg == ST_RUN) begin
                k_reg <= k_reg + 1'b1;
                p_reg <= inc_ptr(p_reg);
                if (last && (mode_reg == MODE_LINEAR)) begin
                    wp_reg <= inc_ptr(wp_reg);
                end
            end
        end
        if (accept && (in_cmd == CMD_SAMPLE)) begin
            x_reg <= in_sample;
        end
    end

endmodule

[rtl/core/fractional_delay_line.sv]
// Fractional delay line: top level with the sample and tap memories and the result register.
//
// Delays a signed sample stream by a whole number of samples plus a Q15 fraction, either by
// two-point linear interpolation or by a windowed sinc FIR of 2N loaded taps. One request
// is worked on at a time. A coefficient load, and a sinc sample that is still being absorbed
// into the window, are finished as soon as they are taken. Any other sample waits on its tap
// reads: the delay memory has one read port and the taps are fetched one per cycle into a
// registered multiply and accumulate. A finished result waits in the output register while
// the next request is already taken. After reset both memories are swept to zero across
// max(BUFFER_DEPTH, 2*MAX_SIDELOBES) entries, during which no request is accepted;
// configuration writes are taken at any time the block is idle.
module fractional_delay_line #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int MAX_SIDELOBES = 16,
    parameter int SAMPLE_BITS   = 16,
    localparam int IN_W  = ((SAMPLE_BITS + fdl_pkg::COEF_INDEX_W + fdl_pkg::COEF_W + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fdl_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: sample_in, coef_index, coef_value, zero padding.
    input  logic [IN_W-1:0]                 s_tdata,
    // Fields from bit 0: cmd.
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: delayed_sample, zero padding.
    output logic [OUT_W-1:0]                m_tdata
);

    import fdl_pkg::*;

    localparam int TAPS = 2 * MAX_SIDELOBES;
    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int TAW  = $clog2(TAPS);

    logic                          result_load;
    logic                          out_free;
    logic                          smp_we;
    logic [AW-1:0]                 smp_waddr;
    logic [SAMPLE_BITS-1:0]        smp_wdata;
    logic [AW-1:0]                 smp_raddr;
    logic [SAMPLE_BITS-1:0]        smp_rdata;
    logic                          tap_we;
    logic [TAW-1:0]                tap_waddr;
    logic [COEF_W-1:0]             tap_wdata;
    logic [TAW-1:0]                tap_raddr;
    logic [COEF_W-1:0]             tap_rdata;
    fdl_mac_ctl_t                  mac_ctl;
    logic                          mac_busy;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic [FRACTION_W-1:0]         frac;
    logic signed [SAMPLE_BITS-1:0] result;

    logic                          m_valid_reg;
    logic [SAMPLE_BITS-1:0]        m_data_reg;

    fdl_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_SIDELOBES(MAX_SIDELOBES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser[0]),
        .in_sample    (s_tdata[SAMPLE_BITS-1:0]),
        .in_coef_index(s_tdata[SAMPLE_BITS+COEF_INDEX_W-1:SAMPLE_BITS]),
        .in_coef_value(s_tdata[SAMPLE_BITS+COEF_INDEX_W+COEF_W-1:SAMPLE_BITS+COEF_INDEX_W]),
        .out_free     (out_free),
        .result_load  (result_load),
        .smp_we       (smp_we),
        .smp_waddr    (smp_waddr),
        .smp_wdata    (smp_wdata),
        .smp_raddr    (smp_raddr),
        .tap_we       (tap_we),
        .tap_waddr    (tap_waddr),
        .tap_wdata    (tap_wdata),
        .tap_raddr    (tap_raddr),
        .mac_ctl      (mac_ctl),
        .mac_busy     (mac_busy),
        .sample_x     (sample_x),
        .frac         (frac)
    );

    fdl_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(BUFFER_DEPTH)
    ) u_sample_ram (
        .aclk (aclk),
        .we   (smp_we),
        .waddr(smp_waddr),
        .wdata(smp_wdata),
        .raddr(smp_raddr),
        .rdata(smp_rdata)
    );

    fdl_ram #(
        .WIDTH(COEF_W),
        .DEPTH(TAPS)
    ) u_tap_ram (
        .aclk (aclk),
        .we   (tap_we),
        .waddr(tap_waddr),
        .wdata(tap_wdata),
        .raddr(tap_raddr),
        .rdata(tap_rdata)
    );

    fdl_mac #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_SIDELOBES(MAX_SIDELOBES)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .tap_rdata(tap_rdata),
        .smp_rdata(smp_rdata),
        .sample_x (sample_x),
        .frac     (frac),
        .busy     (mac_busy),
        .result   (result)
    );

    // The result register counts as free when it is empty or in the same cycle as its contents are taken.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (result_load) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the fractional delay line in linear and windowed sinc modes.
module testbench;
    import fdl_pkg::*;

    localparam int DEPTH         = 256;
    localparam int MAX_LOBES     = 16;
    localparam int TAPS          = 2 * MAX_LOBES;
    localparam int SAMPLE_W      = 16;
    localparam int IN_W          = 40;
    localparam int OUT_W         = 16;
    localparam int ITEMS         = 1900;
    localparam int SETTLE_CYCLES = 64;
    localparam longint CYCLE_LIMIT = 1_000_000;

    // Tracks the delay store, the tap table and the window position, and keeps the
    // delayed samples that are still owed by the block in order of arrival.
    class delay_scoreboard;
        logic signed [SAMPLE_W-1:0] history [DEPTH];
        logic signed [COEF_W-1:0]   taps [TAPS];
        logic [7:0]                 wr_ptr;
        logic [7:0]                 win_ptr;
        int unsigned                absorb_left;
        logic                       mode;
        logic [WHOLE_W-1:0]         whole;
        logic [FRACTION_W-1:0]      fraction;
        logic [SIDELOBE_W-1:0]      lobes;
        logic signed [SAMPLE_W-1:0] awaited [$];
        int unsigned failures;
        int unsigned linear_results;
        int unsigned sinc_results;
        int unsigned absorbed;
        int unsigned coef_loads;
        int unsigned reg_writes;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (taps[i]) taps[i] = '0;
            wr_ptr = '0;
            mode = MODE_LINEAR;
            whole = '0;
            fraction = '0;
            lobes = 1;
            failures = 0;
            linear_results = 0;
            sinc_results = 0;
            absorbed = 0;
            coef_loads = 0;
            reg_writes = 0;
            rearm();
        endfunction

        function int unsigned lobe_count();
            if (lobes == 0) return 1;
            return (lobes > MAX_LOBES) ? MAX_LOBES : lobes;
        endfunction

        function int unsigned frac_q15();
            return (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
        endfunction

        // Every write to one of the four registers restarts the window from the current write position.
        function void rearm();
            int unsigned n;
            int unsigned c;
            int unsigned off;
            n = lobe_count();
            c = whole + ((frac_q15() > 0) ? 1 : 0);
            off = (n + c - 1) % DEPTH;
            absorb_left = (n > c) ? n - c : 0;
            win_ptr = (wr_ptr + DEPTH - off) % DEPTH;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_MODE:     mode = data[0];
                REG_WHOLE:    whole = data[WHOLE_W-1:0];
                REG_FRACTION: fraction = data;
                REG_SIDELOBE: lobes = data[SIDELOBE_W-1:0];
                default:      return;
            endcase
            reg_writes++;
            rearm();
        endfunction

        function logic signed [SAMPLE_W-1:0] round_q15(longint sum);
            longint q;
            q = (sum + ROUND_HALF) >>> FRAC_SHIFT;
            if (q > 32767) q = 32767;
            else if (q < -32768) q = -32768;
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_request(logic cmd, logic signed [SAMPLE_W-1:0] sample,
                                   logic [COEF_INDEX_W-1:0] index,
                                   logic signed [COEF_W-1:0] value);
            longint acc;
            longint f;
            longint left;
            longint right;
            int unsigned d;
            int unsigned k;
            logic [7:0] li;
            logic [7:0] ri;
            logic [7:0] p;
            if (cmd == CMD_COEF) begin
                taps[index] = value;
                coef_loads++;
                return;
            end
            if (mode == MODE_LINEAR) begin
                d = whole;
                f = frac_q15();
                li = wr_ptr - d - 1;
                ri = wr_ptr - d;
                left = history[li];
                // With no whole delay the newest sample is the one arriving now.
                right = (d == 0) ? sample : history[ri];
                acc = f * left + (32768 - f) * right;
                history[wr_ptr] = sample;
                wr_ptr++;
                awaited.push_back(round_q15(acc));
                linear_results++;
                return;
            end
            history[wr_ptr] = sample;
            wr_ptr++;
            if (absorb_left > 0) begin
                absorb_left--;
                absorbed++;
                return;
            end
            acc = 0;
            p = win_ptr;
            for (k = 0; k < 2 * lobe_count(); k++) begin
                acc += longint'(history[p]) * longint'(taps[k]);
                p++;
            end
            win_ptr++;
            awaited.push_back(round_q15(acc));
            sinc_results++;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] want;
            if (awaited.size() == 0) begin
                $error("delayed_sample: nothing expected, actual %0d", actual);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (actual !== want) begin
                $error("delayed_sample: expected %0d, actual %0d", want, actual);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;

    delay_scoreboard board;
    bit              quiet = 1'b0;
    longint          cycles = 0;
    int unsigned     hold_left = 0;
    int unsigned     requests_sent = 0;
    int unsigned     settings_applied = 0;

    fractional_delay_line #(
        .BUFFER_DEPTH (DEPTH),
        .MAX_SIDELOBES(MAX_LOBES),
        .SAMPLE_BITS  (SAMPLE_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] sample_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'h7FFF;
        if (r < 10) return 16'h8000;
        if (r < 30) return 16'($urandom_range(0, 511) - 256);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] tap_value(int unsigned shift);
        logic signed [15:0] t;
        t = 16'($urandom);
        return t >>> shift;
    endfunction

    // Requests, register writes and results are all noted at the edge that takes them.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) board.write_register(cfg_wr_index, cfg_wr_data);
            if (s_tvalid && s_tready)
                board.note_request(s_tuser[0], s_tdata[15:0], s_tdata[20:16], s_tdata[36:21]);
            if (m_tvalid && m_tready) board.check_result(m_tdata[15:0]);
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            m_tready <= 1'b0;
            hold_left <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("cycle limit hit with %0d results outstanding", board.awaited.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [15:0] sample, logic [4:0] index,
                                logic [15:0] value);
        int unsigned gap;
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, value, index, sample};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // Leaves the enable high between writes; the caller lowers it after the last one.
    task automatic put_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic program_line(logic [15:0] mode_word, logic [15:0] whole_word,
                                logic [15:0] fraction_word, logic [15:0] lobe_word,
                                bit with_unused);
        if (with_unused) put_reg(REG_SIDELOBE + 3'($urandom_range(1, 4)), 16'($urandom));
        put_reg(REG_MODE, mode_word);
        put_reg(REG_WHOLE, whole_word);
        put_reg(REG_FRACTION, fraction_word);
        put_reg(REG_SIDELOBE, lobe_word);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // The extra edge makes sure the last request has been noted before the queue is read.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase();
        logic        mode;
        logic [7:0]  whole;
        logic [15:0] fraction;
        logic [4:0]  lobes;
        bit          junk;
        int unsigned n;
        int unsigned k;
        int unsigned count;
        int unsigned shift;
        int unsigned r;
        mode = $urandom_range(0, 1) ? MODE_SINC : MODE_LINEAR;
        r = $urandom_range(0, 99);
        if (r < 50) whole = $urandom_range(0, 6);
        else if (r < 80) whole = $urandom_range(0, 255);
        else if (r < 90) whole = 8'd255;
        else whole = 8'd0;
        r = $urandom_range(0, 99);
        if (r < 25) fraction = 16'd0;
        else if (r < 40) fraction = FRAC_ONE;
        else if (r < 50) fraction = $urandom_range(32769, 65535);
        else if (r < 55) fraction = 16'd1;
        else if (r < 60) fraction = 16'd32767;
        else fraction = $urandom_range(0, 32768);
        r = $urandom_range(0, 99);
        if (r < 10) lobes = 5'd0;
        else if (r < 20) lobes = $urandom_range(17, 31);
        else if (r < 35) lobes = 5'd16;
        else lobes = $urandom_range(1, 16);
        junk = $urandom_range(0, 1);
        // Bits above the mode, whole and sidelobe widths are sometimes set and must be dropped.
        program_line({junk ? 15'($urandom) : 15'd0, mode},
                     {junk ? 8'($urandom) : 8'd0, whole},
                     fraction,
                     {junk ? 11'($urandom) : 11'd0, lobes},
                     $urandom_range(0, 3) == 0);
        quiet = ($urandom_range(0, 4) == 0);
        shift = $urandom_range(0, 6);
        if (mode == MODE_SINC && $urandom_range(0, 9) != 0) begin
            n = (lobes == 0) ? 1 : ((lobes > MAX_LOBES) ? MAX_LOBES : lobes);
            for (k = 0; k < 2 * n; k++)
                send_request(CMD_COEF, 16'($urandom), 5'(k), tap_value(shift));
        end
        count = $urandom_range(30, 150);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 8)
                send_request(CMD_COEF, 16'($urandom), 5'($urandom), tap_value(shift));
            else
                send_request(CMD_SAMPLE, sample_value(), 5'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int unsigned target;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // The memories are swept clear after reset before the block takes anything.
        repeat (DEPTH + SETTLE_CYCLES) @(posedge aclk);

        // Reset settings: linear with no delay, so each sample comes straight back.
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h8000, 5'd31, 16'hFFFF);
        send_request(CMD_SAMPLE, 16'h0000, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'hFFFF, 5'd21, 16'h5555);
        send_request(CMD_COEF, 16'h0000, 5'd0, 16'h7FFF);
        send_request(CMD_COEF, 16'hFFFF, 5'd1, 16'h8000);
        send_request(CMD_COEF, 16'h1234, 5'd2, 16'h4000);
        send_request(CMD_COEF, 16'h0000, 5'd31, 16'h8000);
        drain();

        program_line(MODE_LINEAR, 16'd2, 16'd16384, 16'd1, 1'b0);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'd100, 5'd0, 16'h0000);
        drain();

        // A fraction above one counts as one; the whole delay is at its longest.
        program_line(MODE_LINEAR, 16'd255, 16'hFFFF, 16'd1, 1'b0);
        send_request(CMD_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        drain();

        // No sidelobes counts as one, and with no delay the first sample is absorbed.
        program_line(MODE_SINC, 16'd0, 16'd0, 16'd0, 1'b0);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        drain();

        // Too many sidelobes are clamped, and a window this far back wraps round the store.
        program_line(MODE_SINC, 16'd255, FRAC_ONE, 16'd31, 1'b1);
        send_request(CMD_SAMPLE, 16'h7FFF, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h8000, 5'd0, 16'h0000);
        send_request(CMD_SAMPLE, 16'h0001, 5'd0, 16'h0000);
        drain();

        target = requests_sent + ITEMS;
        while (requests_sent < target) begin
            random_phase();
            drain();
        end

        $display("%0d requests: %0d linear and %0d sinc results, %0d absorbed, %0d tap loads",
                 requests_sent, board.linear_results, board.sinc_results, board.absorbed,
                 board.coef_loads);
        $display("%0d register writes across %0d settings, %0d mismatches",
                 board.reg_writes, settings_applied, board.failures);
        if (board.failures == 0 && board.awaited.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
